/* rtl/ott_pkg.sv */
// Shared constants for the object tracker table.
// No dependencies.
package ott_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned CLASS_W = 8;
    localparam int unsigned Q16_W   = 16;
    localparam int unsigned MISS_W  = 8;
    localparam int unsigned SIZE_W  = 12;
    localparam int unsigned OUTC_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [OUTC_W-1:0] OUTC_DROP    = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_REUSE   = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_CREATE  = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_FULL    = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_FRAME   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd3;

endpackage

/* rtl/ott_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ott_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ott_iou_unit.sv */
// Multi-cycle IoU threshold compare with one shared multiplier.
// Depends on ott_pkg.
module ott_iou_unit import ott_pkg::*; #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_l1,
    input  logic [COORD_BITS-1:0] i_t1,
    input  logic [COORD_BITS-1:0] i_w1,
    input  logic [COORD_BITS-1:0] i_h1,
    input  logic [COORD_BITS-1:0] i_l2,
    input  logic [COORD_BITS-1:0] i_t2,
    input  logic [COORD_BITS-1:0] i_w2,
    input  logic [COORD_BITS-1:0] i_h2,
    input  logic [Q16_W-1:0]      i_thr,
    output logic                  o_done,
    output logic                  o_hit
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned AW = 2 * C;      // area
    localparam int unsigned UW = 2 * C + 1;  // union
    localparam int unsigned PW = UW + Q16_W; // product

    typedef enum logic [2:0] {
        U_IDLE, U_EDGE, U_M_INT, U_M_A1, U_M_A2, U_UNI, U_M_THR, U_CMP
    } t_ustate;

    t_ustate r_state;
    logic [C-1:0]  r_l1, r_t1, r_w1, r_h1, r_l2, r_t2, r_w2, r_h2;
    logic [Q16_W-1:0] r_thr;
    logic [C-1:0]  r_iw, r_ih;
    logic          r_empty;
    logic [AW-1:0] r_inter, r_area;
    logic [UW-1:0] r_uni;
    logic [PW-1:0] r_prod;
    logic          r_done, r_hit;

    logic [C-1:0] ix1, iy1;
    logic [C:0]   rr1, rr2, bb1, bb2, ix2, iy2;
    logic [UW-1:0]    mul_a;
    logic [Q16_W-1:0] mul_b;

    always_comb begin
        ix1 = (r_l1 > r_l2) ? r_l1 : r_l2;
        iy1 = (r_t1 > r_t2) ? r_t1 : r_t2;
        rr1 = {1'b0, r_l1} + {1'b0, r_w1};
        rr2 = {1'b0, r_l2} + {1'b0, r_w2};
        bb1 = {1'b0, r_t1} + {1'b0, r_h1};
        bb2 = {1'b0, r_t2} + {1'b0, r_h2};
        ix2 = (rr1 < rr2) ? rr1 : rr2;
        iy2 = (bb1 < bb2) ? bb1 : bb2;
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            U_M_INT: begin
                mul_a = UW'(r_iw);
                mul_b = Q16_W'(r_ih);
            end
            U_M_A1: begin
                mul_a = UW'(r_w1);
                mul_b = Q16_W'(r_h1);
            end
            U_M_A2: begin
                mul_a = UW'(r_w2);
                mul_b = Q16_W'(r_h2);
            end
            U_M_THR: begin
                mul_a = r_uni;
                mul_b = r_thr;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_prod <= PW'(mul_a) * PW'(mul_b);
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_l1 <= i_l1; r_t1 <= i_t1; r_w1 <= i_w1; r_h1 <= i_h1;
                        r_l2 <= i_l2; r_t2 <= i_t2; r_w2 <= i_w2; r_h2 <= i_h2;
                        r_thr <= i_thr;
                        r_state <= U_EDGE;
                    end
                end
                U_EDGE: begin
                    // width never exceeds the narrower box, so C bits suffice
                    r_empty <= (ix2 < {1'b0, ix1}) || (iy2 < {1'b0, iy1});
                    r_iw    <= C'(ix2 - {1'b0, ix1});
                    r_ih    <= C'(iy2 - {1'b0, iy1});
                    r_state <= U_M_INT;
                end
                U_M_INT: r_state <= U_M_A1;
                U_M_A1: begin
                    r_inter <= r_prod[AW-1:0];
                    r_state <= U_M_A2;
                end
                U_M_A2: begin
                    r_area  <= r_prod[AW-1:0];
                    r_state <= U_UNI;
                end
                U_UNI: begin
                    r_uni   <= UW'(r_area) + UW'(r_prod[AW-1:0]) - UW'(r_inter);
                    r_state <= U_M_THR;
                end
                U_M_THR: r_state <= U_CMP;
                U_CMP: begin
                    r_done  <= 1'b1;
                    r_hit   <= !r_empty && (r_uni != '0) &&
                               (PW'({r_inter, {Q16_W{1'b0}}}) > r_prod);
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;

endmodule

/* rtl/iou_object_tracker_table.sv */
// Greedy IoU object tracker table, top level: sequencer, table store, registers.
// Depends on ott_pkg, ott_ram and ott_iou_unit.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one opcode per transaction:
//    a frame advance or a detection (class, confidence, box).
//  - Output channel (o_out_valid / i_out_stall) returns one transaction per
//    input: object id and outcome code.
//  - Config channel (i_cfg_valid / o_cfg_ready) writes the four thresholds;
//    always ready, write only while the block is idle.
//  - Frame advance and dropped detections skip the table walk and go straight
//    from acceptance to the emit step.
//  - A detection walks every slot in order: a read and a check step per slot,
//    plus a wait on the IoU unit for each live same-class entry; then a decide
//    step writes back and an emit step loads the output register. The single
//    IoU compare unit and its shared multiplier set the pace of the walk.
//  - One transaction is worked on at a time; the next can be taken in the cycle
//    after the result is loaded, even while that result is still held.
//  - A stalled result holds in the output register; a finished transaction
//    waits in its emit step until the register frees up.
//  - Reset clears slot valid bits, both counters and reloads register defaults;
//    the table RAM content is left untouched.
module iou_object_tracker_table import ott_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned COORD_BITS    = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // detection / frame transactions
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [CLASS_W-1:0]    i_class_index,
    input  logic [Q16_W-1:0]      i_confidence,
    input  logic [COORD_BITS-1:0] i_box_left,
    input  logic [COORD_BITS-1:0] i_box_top,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ID_W-1:0]       o_object_id,
    output logic [OUTC_W-1:0]     o_outcome,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [Q16_W-1:0]      i_cfg_data
);

    localparam int unsigned C      = COORD_BITS;
    localparam int unsigned IW     = $clog2(TABLE_ENTRIES);
    localparam int unsigned WORD_W = CLASS_W + 4 * C + FRAME_W + ID_W;
    localparam int unsigned EXT_W  = 16; // common width for size compares

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_WAIT, S_DECIDE, S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [Q16_W-1:0]  r_iou_thr, r_conf_thr;
    logic [MISS_W-1:0] r_max_miss;
    logic [SIZE_W-1:0] r_min_size;

    // tracker state
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [FRAME_W-1:0] r_frame;
    logic [ID_W-1:0]    r_created;

    // latched detection
    logic [CLASS_W-1:0] r_cls;
    logic [C-1:0]       r_l, r_t, r_w, r_h;

    // scan state
    logic [IW-1:0] r_idx, r_best_idx, r_spare_idx;
    logic          r_best_ok, r_spare_ok;
    logic [ID_W-1:0] r_best_id;

    // result
    logic [ID_W-1:0]   r_res_id, r_obj_id;
    logic [OUTC_W-1:0] r_res_outc, r_outcome;
    logic              r_out_valid;

    // RAM interface
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    // decoded slot fields
    logic [CLASS_W-1:0] rd_cls;
    logic [C-1:0]       rd_l, rd_t, rd_w, rd_h;
    logic [FRAME_W-1:0] rd_last;
    logic [ID_W-1:0]    rd_id;

    logic in_acc, drop, live, match_cls, iou_start, iou_done, iou_hit;
    logic last_idx, out_free;
    logic [ID_W-1:0] new_id;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    assign drop = (i_confidence < r_conf_thr) ||
                  (EXT_W'(i_box_width)  < EXT_W'(r_min_size)) ||
                  (EXT_W'(i_box_height) < EXT_W'(r_min_size));

    assign {rd_cls, rd_l, rd_t, rd_w, rd_h, rd_last, rd_id} = mem_rdata;

    // stale once unseen for more than the miss limit (wrapping age)
    assign live      = r_valid[r_idx] &&
                       ((r_frame - rd_last) <= FRAME_W'(r_max_miss));
    assign match_cls = (rd_cls == r_cls);
    assign iou_start = (r_state == S_CHK) && live && match_cls;
    assign last_idx  = (r_idx == IW'(TABLE_ENTRIES - 1));
    assign new_id    = r_created + ID_W'(1);

    // write back on decide: refresh the matched entry or fill a spare slot
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_spare_idx;
        mem_wdata = {r_cls, r_l, r_t, r_w, r_h, r_frame, new_id};
        if (r_state == S_DECIDE) begin
            if (r_best_ok) begin
                mem_we    = 1'b1;
                mem_waddr = r_best_idx;
                mem_wdata = {r_cls, r_l, r_t, r_w, r_h, r_frame, r_best_id};
            end else begin
                mem_we    = r_spare_ok;
            end
        end
    end

    ott_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    ott_iou_unit #(
        .COORD_BITS (C)
    ) u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iou_start),
        .i_l1    (r_l),
        .i_t1    (r_t),
        .i_w1    (r_w),
        .i_h1    (r_h),
        .i_l2    (rd_l),
        .i_t2    (rd_t),
        .i_w2    (rd_w),
        .i_h2    (rd_h),
        .i_thr   (r_iou_thr),
        .o_done  (iou_done),
        .o_hit   (iou_hit)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr  <= 16'd32768;
            r_conf_thr <= 16'd32768;
            r_max_miss <= 8'd30;
            r_min_size <= 12'd20;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IOU_THR:  r_iou_thr  <= i_cfg_data;
                CFG_CONF_THR: r_conf_thr <= i_cfg_data;
                CFG_MAX_MISS: r_max_miss <= i_cfg_data[MISS_W-1:0];
                CFG_MIN_SIZE: r_min_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_frame     <= '0;
            r_created   <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
            r_spare_ok  <= 1'b0;
        end else begin
            // the emit step reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cls <= i_class_index;
                        r_l   <= i_box_left;
                        r_t   <= i_box_top;
                        r_w   <= i_box_width;
                        r_h   <= i_box_height;
                        r_idx      <= '0;
                        r_best_ok  <= 1'b0;
                        r_spare_ok <= 1'b0;
                        r_res_id   <= '0;
                        if (i_opcode) begin
                            r_frame    <= r_frame + FRAME_W'(1);
                            r_res_outc <= OUTC_FRAME;
                            r_state    <= S_EMIT;
                        end else if (drop) begin
                            r_res_outc <= OUTC_DROP;
                            r_state    <= S_EMIT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (iou_start) begin
                        r_state <= S_WAIT;
                    end else begin
                        if (!live && !r_spare_ok) begin
                            r_spare_ok  <= 1'b1;
                            r_spare_idx <= r_idx;
                        end
                        if (last_idx) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_WAIT: begin
                    if (iou_done) begin
                        // lowest identity wins among matches
                        if (iou_hit && (!r_best_ok || rd_id < r_best_id)) begin
                            r_best_ok  <= 1'b1;
                            r_best_idx <= r_idx;
                            r_best_id  <= rd_id;
                        end
                        if (last_idx) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_best_ok) begin
                        r_res_id   <= r_best_id;
                        r_res_outc <= OUTC_REUSE;
                    end else begin
                        r_created <= new_id;
                        r_res_id  <= new_id;
                        if (r_spare_ok) begin
                            r_valid[r_spare_idx] <= 1'b1;
                            r_res_outc <= OUTC_CREATE;
                        end else begin
                            r_res_outc <= OUTC_FULL;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_obj_id    <= r_res_id;
                        r_outcome   <= r_res_outc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_object_id = r_obj_id;
    assign o_outcome   = r_outcome;

endmodule
